// ----- sv/windowed_alignment_depth_binner_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the windowed alignment depth binner
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_ALIGNMENT_DEPTH_BINNER_MACROS_SVH
`define WINDOWED_ALIGNMENT_DEPTH_BINNER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define WADB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("binner check failed: same-cycle implication");
// next-cycle implication
`define WADB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("binner check failed: next-cycle implication");
`else
`define WADB_ASSERT_IMP(lbl, ante, cons)
`define WADB_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- sv/wadb_pkg.sv -----
// ----------------------------------------------------------------------------
// wadb_pkg
// Shared types and constants of the windowed alignment depth binner.
// ----------------------------------------------------------------------------
package wadb_pkg;

    localparam int POS_W    = 31;
    localparam int WS_W     = 21;
    localparam int MQ_W     = 8;
    localparam int FLAG_W   = 16;
    localparam int CODE_W   = 4;
    localparam int IDX_W    = 18;
    localparam int CUR_W    = 32;
    localparam int COV_W    = 32;
    localparam int DEPTH_W  = 40;
    localparam int DIVD_W   = 40;
    localparam int DIVS_W   = WS_W;
    localparam int DCNT_W   = 6;
    localparam int BSTART_W = IDX_W + WS_W;
    localparam int CFG_IDX_W = 1;

    localparam logic [WS_W-1:0]   RESET_WINDOW = WS_W'(1000);
    localparam logic [MQ_W-1:0]   RESET_MIN_MQ = MQ_W'(20);
    localparam logic [FLAG_W-1:0] FLAG_DROP_MASK = 16'h0D04;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MAPQ    = 1'b1;

    localparam logic [1:0] REQ_CONTIG = 2'd0;
    localparam logic [1:0] REQ_HEADER = 2'd1;
    localparam logic [1:0] REQ_CIGAR  = 2'd2;
    localparam logic [1:0] REQ_BIN    = 2'd3;

    localparam logic [CODE_W-1:0] CIG_M  = 4'd0;
    localparam logic [CODE_W-1:0] CIG_D  = 4'd2;
    localparam logic [CODE_W-1:0] CIG_N  = 4'd3;
    localparam logic [CODE_W-1:0] CIG_EQ = 4'd7;
    localparam logic [CODE_W-1:0] CIG_X  = 4'd8;

    typedef enum logic [1:0] {
        DIV_CONTIG = 2'd0,
        DIV_POS    = 2'd1,
        DIV_DEPTH  = 2'd2
    } div_sel_t;

    typedef enum logic [10:0] {
        ST_CLEAR = 11'b00000000001,
        ST_IDLE  = 11'b00000000010,
        ST_DIV_N = 11'b00000000100,
        ST_DIV_W = 11'b00000001000,
        ST_LCHK  = 11'b00000010000,
        ST_LRD   = 11'b00000100000,
        ST_BMUL  = 11'b00001000000,
        ST_BCHK  = 11'b00010000000,
        ST_BRD   = 11'b00100000000,
        ST_DIV_D = 11'b01000000000,
        ST_PUSH  = 11'b10000000000
    } state_t;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [POS_W-1:0]  ref_position;
        logic [POS_W-1:0]  span_length;
        logic [FLAG_W-1:0] read_flags;
        logic [MQ_W-1:0]   map_quality;
        logic [CODE_W-1:0] cigar_code;
        logic [IDX_W-1:0]  bin_index;
    } req_t;

    typedef struct packed {
        logic [POS_W-1:0]   bin_start;
        logic [POS_W-1:0]   bin_end;
        logic [COV_W-1:0]   covered_bases;
        logic [DEPTH_W-1:0] depth_fixed;
        logic               bin_out_of_range;
    } res_t;

    typedef struct packed {
        logic     in_ready;
        logic     in_fire;
        logic     div_start;
        div_sel_t div_sel;
        logic     load_count;
        logic     clr_step;
        logic     load_wpos;
        logic     mem_rd_loop;
        logic     loop_adv;
        logic     bin_mul;
        logic     bin_chk;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       match_go;
        logic       div_done;
        logic       div_busy;
        logic       clr_last;
        logic       loop_ok;
        logic       bin_oor;
        logic       out_free;
    } sts_t;

endpackage

// ----- sv/wadb_req_if.sv -----
// ----------------------------------------------------------------------------
// wadb_req_if
// Request channel: valid/ready handshake carrying one request item.
// ----------------------------------------------------------------------------
interface wadb_req_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      req_type;
    logic [wadb_pkg::POS_W-1:0]      ref_position;
    logic [wadb_pkg::POS_W-1:0]      span_length;
    logic [wadb_pkg::FLAG_W-1:0]     read_flags;
    logic [wadb_pkg::MQ_W-1:0]       map_quality;
    logic [wadb_pkg::CODE_W-1:0]     cigar_code;
    logic [wadb_pkg::IDX_W-1:0]      bin_index;

    modport source (output valid, req_type, ref_position, span_length, read_flags,
                    map_quality, cigar_code, bin_index, input ready);
    modport sink   (input valid, req_type, ref_position, span_length, read_flags,
                    map_quality, cigar_code, bin_index, output ready);
endinterface

// ----- sv/wadb_res_if.sv -----
// ----------------------------------------------------------------------------
// wadb_res_if
// Result channel: valid/ready handshake carrying one bin report item.
// ----------------------------------------------------------------------------
interface wadb_res_if;
    logic                            valid;
    logic                            ready;
    logic [wadb_pkg::POS_W-1:0]      bin_start;
    logic [wadb_pkg::POS_W-1:0]      bin_end;
    logic [wadb_pkg::COV_W-1:0]      covered_bases;
    logic [wadb_pkg::DEPTH_W-1:0]    depth_fixed;
    logic                            bin_out_of_range;

    modport source (output valid, bin_start, bin_end, covered_bases, depth_fixed,
                    bin_out_of_range, input ready);
    modport sink   (input valid, bin_start, bin_end, covered_bases, depth_fixed,
                    bin_out_of_range, output ready);
endinterface

// ----- sv/wadb_div.sv -----
// ----------------------------------------------------------------------------
// wadb_div
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
module wadb_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [wadb_pkg::DIVD_W-1:0]   dividend,
    input  logic [wadb_pkg::DIVS_W-1:0]   divisor,
    output logic [wadb_pkg::DIVD_W-1:0]   quotient,
    output logic [wadb_pkg::DIVS_W-1:0]   remainder,
    output logic                          busy,
    output logic                          done
);
    logic [wadb_pkg::DIVD_W-1:0] quo_reg, quo_next;
    logic [wadb_pkg::DIVS_W-1:0] rem_reg, rem_next;
    logic [wadb_pkg::DIVS_W-1:0] dsr_reg, dsr_next;
    logic [wadb_pkg::DCNT_W-1:0] cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [wadb_pkg::DIVS_W:0]   shifted;
    logic [wadb_pkg::DIVS_W:0]   trial;

    assign shifted = {rem_reg, quo_reg[wadb_pkg::DIVD_W-1]};
    assign trial   = shifted - {1'b0, dsr_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = wadb_pkg::DCNT_W'(wadb_pkg::DIVD_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[wadb_pkg::DIVS_W])
            begin
                rem_next = trial[wadb_pkg::DIVS_W-1:0];
                quo_next = {quo_reg[wadb_pkg::DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[wadb_pkg::DIVS_W-1:0];
                quo_next = {quo_reg[wadb_pkg::DIVD_W-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign busy      = busy_reg;
    assign done      = done_reg;
endmodule

// ----- sv/wadb_ctrl.sv -----
// ----------------------------------------------------------------------------
// wadb_ctrl
// Sequencer: takes items, runs divisions, window loop, bin read, clear sweep.
// ----------------------------------------------------------------------------
module wadb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  wadb_pkg::sts_t      sts,
    output wadb_pkg::cmd_t      cmd
);
    wadb_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = wadb_pkg::DIV_CONTIG;
        case (state_reg)
            wadb_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                    state_next = wadb_pkg::ST_IDLE;
            end
            wadb_pkg::ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.in_fire = 1'b1;
                    case (sts.req_type)
                        wadb_pkg::REQ_CONTIG:
                        begin
                            cmd.div_start = 1'b1;
                            cmd.div_sel   = wadb_pkg::DIV_CONTIG;
                            state_next    = wadb_pkg::ST_DIV_N;
                        end
                        wadb_pkg::REQ_CIGAR:
                        begin
                            if (sts.match_go)
                            begin
                                cmd.div_start = 1'b1;
                                cmd.div_sel   = wadb_pkg::DIV_POS;
                                state_next    = wadb_pkg::ST_DIV_W;
                            end
                        end
                        wadb_pkg::REQ_BIN:
                            state_next = wadb_pkg::ST_BMUL;
                        default:
                            state_next = wadb_pkg::ST_IDLE;
                    endcase
                end
            end
            wadb_pkg::ST_DIV_N:
            begin
                if (sts.div_done)
                begin
                    cmd.load_count = 1'b1;
                    state_next     = wadb_pkg::ST_CLEAR;
                end
            end
            wadb_pkg::ST_DIV_W:
            begin
                if (sts.div_done)
                begin
                    cmd.load_wpos = 1'b1;
                    state_next    = wadb_pkg::ST_LCHK;
                end
            end
            wadb_pkg::ST_LCHK:
            begin
                if (sts.loop_ok)
                begin
                    cmd.mem_rd_loop = 1'b1;
                    state_next      = wadb_pkg::ST_LRD;
                end
                else
                begin
                    state_next = wadb_pkg::ST_IDLE;
                end
            end
            wadb_pkg::ST_LRD:
            begin
                cmd.loop_adv = 1'b1;
                state_next   = wadb_pkg::ST_LCHK;
            end
            wadb_pkg::ST_BMUL:
            begin
                cmd.bin_mul = 1'b1;
                state_next  = wadb_pkg::ST_BCHK;
            end
            wadb_pkg::ST_BCHK:
            begin
                cmd.bin_chk = 1'b1;
                state_next  = wadb_pkg::ST_BRD;
            end
            wadb_pkg::ST_BRD:
            begin
                if (sts.bin_oor)
                begin
                    state_next = wadb_pkg::ST_PUSH;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = wadb_pkg::DIV_DEPTH;
                    state_next    = wadb_pkg::ST_DIV_D;
                end
            end
            wadb_pkg::ST_DIV_D:
            begin
                if (sts.div_done)
                    state_next = wadb_pkg::ST_PUSH;
            end
            wadb_pkg::ST_PUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = wadb_pkg::ST_IDLE;
                end
            end
            default:
                state_next = wadb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= wadb_pkg::ST_CLEAR;
        else
            state_reg <= state_next;
    end
endmodule

// ----- sv/wadb_dp.sv -----
// ----------------------------------------------------------------------------
// wadb_dp
// Datapath: config, read state, bin memory, window arithmetic, result reg.
// ----------------------------------------------------------------------------
module wadb_dp #(
    parameter int MAX_BINS = 262144
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [wadb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wadb_pkg::WS_W-1:0]         cfg_wdata,
    input  wadb_pkg::req_t                    rq,
    input  wadb_pkg::cmd_t                    cmd,
    output wadb_pkg::sts_t                    sts,
    input  logic                              res_ready,
    output wadb_pkg::res_t                    res,
    output logic                              res_valid
);
    localparam int ADDR_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int BIN_W  = $clog2(MAX_BINS + 1);
    localparam int LIN_W  = (BIN_W + wadb_pkg::WS_W > 33) ? BIN_W + wadb_pkg::WS_W : 33;

    // config
    logic [wadb_pkg::WS_W-1:0]  win_width_reg;
    logic [wadb_pkg::MQ_W-1:0]  min_mq_reg;
    logic [wadb_pkg::WS_W-1:0]  ws_eff;

    // contig / read state
    logic [wadb_pkg::POS_W-1:0] contig_len_reg;
    logic [BIN_W-1:0]           win_count_reg;
    logic [wadb_pkg::CUR_W-1:0] cursor_reg;
    logic                       read_ok_reg;

    // window loop
    logic [wadb_pkg::CUR_W-1:0] bstart_reg;
    logic [32:0]                bend_reg;
    logic [BIN_W-1:0]           w_reg;
    logic [LIN_W-1:0]           ws0_reg;
    logic [LIN_W-1:0]           lo, hi, we0;
    logic [wadb_pkg::COV_W-1:0] add_val;

    // bin read
    logic [wadb_pkg::IDX_W-1:0]    idx_reg;
    logic [wadb_pkg::BSTART_W-1:0] start_reg;
    logic [wadb_pkg::BSTART_W-1:0] end_full;
    logic [wadb_pkg::POS_W-1:0]    end_reg;
    logic [wadb_pkg::WS_W-1:0]     width_reg;
    logic                          oor_reg;
    logic                          oor_now;

    // memory
    logic [wadb_pkg::COV_W-1:0] mem [MAX_BINS];
    logic [wadb_pkg::COV_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]          clr_addr_reg;
    logic                       mem_we, mem_re;
    logic [ADDR_W-1:0]          waddr, raddr;
    logic [wadb_pkg::COV_W-1:0] wdata;

    // divider
    logic [wadb_pkg::DIVD_W-1:0] div_dvd, div_q;
    logic [wadb_pkg::DIVS_W-1:0] div_dsr, div_r;
    logic                        div_busy, div_done;

    // result
    wadb_pkg::res_t res_reg;
    logic           res_valid_reg;

    logic is_match, consumes;

    assign ws_eff = (win_width_reg == '0) ? wadb_pkg::WS_W'(1) : win_width_reg;

    assign is_match = (rq.cigar_code == wadb_pkg::CIG_M) || (rq.cigar_code == wadb_pkg::CIG_EQ)
                   || (rq.cigar_code == wadb_pkg::CIG_X);
    assign consumes = is_match || (rq.cigar_code == wadb_pkg::CIG_D)
                   || (rq.cigar_code == wadb_pkg::CIG_N);

    // overlap of the op with the current window
    assign we0     = ws0_reg + LIN_W'(ws_eff);
    assign lo      = (LIN_W'(bstart_reg) > ws0_reg) ? LIN_W'(bstart_reg) : ws0_reg;
    assign hi      = (LIN_W'(bend_reg) < we0) ? LIN_W'(bend_reg) : we0;
    assign add_val = wadb_pkg::COV_W'(hi - lo);

    // bin read range
    assign oor_now  = (32'(idx_reg) >= 32'(win_count_reg))
                   || (start_reg >= wadb_pkg::BSTART_W'(contig_len_reg));
    assign end_full = ((start_reg + wadb_pkg::BSTART_W'(ws_eff))
                       > wadb_pkg::BSTART_W'(contig_len_reg))
                    ? wadb_pkg::BSTART_W'(contig_len_reg)
                    : start_reg + wadb_pkg::BSTART_W'(ws_eff);

    always_comb
    begin
        case (cmd.div_sel)
            wadb_pkg::DIV_CONTIG:
                div_dvd = wadb_pkg::DIVD_W'(rq.span_length) + wadb_pkg::DIVD_W'(ws_eff)
                        - wadb_pkg::DIVD_W'(1);
            wadb_pkg::DIV_POS:
                div_dvd = wadb_pkg::DIVD_W'(cursor_reg);
            wadb_pkg::DIV_DEPTH:
                div_dvd = {rd_data_reg, 8'd0};
            default:
                div_dvd = '0;
        endcase
    end
    assign div_dsr = (cmd.div_sel == wadb_pkg::DIV_DEPTH) ? width_reg : ws_eff;

    wadb_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dvd),
        .divisor   (div_dsr),
        .quotient  (div_q),
        .remainder (div_r),
        .busy      (div_busy),
        .done      (div_done)
    );

    // config and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_width_reg   <= wadb_pkg::RESET_WINDOW;
            min_mq_reg      <= wadb_pkg::RESET_MIN_MQ;
            contig_len_reg  <= '0;
            win_count_reg   <= '0;
            cursor_reg      <= '0;
            read_ok_reg     <= 1'b0;
            clr_addr_reg    <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    wadb_pkg::CFG_WINDOW_SIZE: win_width_reg <= cfg_wdata;
                    wadb_pkg::CFG_MIN_MAPQ:    min_mq_reg <= cfg_wdata[wadb_pkg::MQ_W-1:0];
                    default:                   min_mq_reg <= min_mq_reg;
                endcase
            end
            if (cmd.in_fire)
            begin
                case (rq.req_type)
                    wadb_pkg::REQ_CONTIG:
                    begin
                        contig_len_reg <= rq.span_length;
                        read_ok_reg    <= 1'b0;
                        cursor_reg     <= '0;
                    end
                    wadb_pkg::REQ_HEADER:
                    begin
                        read_ok_reg <= ((rq.read_flags & wadb_pkg::FLAG_DROP_MASK) == '0)
                                    && (rq.map_quality >= min_mq_reg);
                        cursor_reg  <= wadb_pkg::CUR_W'(rq.ref_position);
                    end
                    wadb_pkg::REQ_CIGAR:
                    begin
                        if (read_ok_reg && consumes)
                            cursor_reg <= cursor_reg + wadb_pkg::CUR_W'(rq.span_length);
                    end
                    default:
                        cursor_reg <= cursor_reg;
                endcase
            end
            if (cmd.load_count)
                win_count_reg <= (div_q > wadb_pkg::DIVD_W'(MAX_BINS))
                               ? BIN_W'(MAX_BINS) : BIN_W'(div_q);
            if (cmd.clr_step)
                clr_addr_reg <= sts.clr_last ? '0 : clr_addr_reg + 1'b1;
            if (cmd.out_load)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.in_fire)
        begin
            bstart_reg <= cursor_reg;
            bend_reg   <= 33'(cursor_reg) + 33'(rq.span_length);
            idx_reg    <= rq.bin_index;
        end
        if (cmd.load_wpos)
        begin
            w_reg   <= (div_q < wadb_pkg::DIVD_W'(win_count_reg)) ? BIN_W'(div_q)
                                                                  : win_count_reg;
            ws0_reg <= LIN_W'(bstart_reg) - LIN_W'(div_r);
        end
        if (cmd.loop_adv)
        begin
            w_reg   <= w_reg + 1'b1;
            ws0_reg <= we0;
        end
        if (cmd.bin_mul)
            start_reg <= wadb_pkg::BSTART_W'(idx_reg) * wadb_pkg::BSTART_W'(ws_eff);
        if (cmd.bin_chk)
        begin
            oor_reg   <= oor_now;
            end_reg   <= wadb_pkg::POS_W'(end_full);
            width_reg <= wadb_pkg::WS_W'(end_full - start_reg);
        end
        if (cmd.out_load)
        begin
            if (oor_reg)
            begin
                res_reg.bin_start        <= '0;
                res_reg.bin_end          <= '0;
                res_reg.covered_bases    <= '0;
                res_reg.depth_fixed      <= '0;
                res_reg.bin_out_of_range <= 1'b1;
            end
            else
            begin
                res_reg.bin_start        <= wadb_pkg::POS_W'(start_reg);
                res_reg.bin_end          <= end_reg;
                res_reg.covered_bases    <= rd_data_reg;
                res_reg.depth_fixed      <= div_q;
                res_reg.bin_out_of_range <= 1'b0;
            end
        end
    end

    // bin memory: one write port, one registered read port
    assign mem_we = cmd.clr_step || cmd.loop_adv;
    assign waddr  = cmd.clr_step ? clr_addr_reg : ADDR_W'(w_reg);
    assign wdata  = cmd.clr_step ? '0 : rd_data_reg + add_val;
    assign mem_re = cmd.mem_rd_loop || cmd.bin_chk;
    assign raddr  = cmd.bin_chk ? ADDR_W'(idx_reg) : ADDR_W'(w_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= wdata;
        if (mem_re)
            rd_data_reg <= mem[raddr];
    end

    assign sts.req_type = rq.req_type;
    assign sts.match_go = read_ok_reg && is_match && (rq.span_length != '0)
                       && (win_count_reg != '0);
    assign sts.div_done = div_done;
    assign sts.div_busy = div_busy;
    assign sts.clr_last = (clr_addr_reg == ADDR_W'(MAX_BINS - 1));
    assign sts.loop_ok  = (w_reg < win_count_reg) && (ws0_reg < LIN_W'(bend_reg));
    assign sts.bin_oor  = oor_reg;
    assign sts.out_free = !res_valid_reg || res_ready;

    assign res       = res_reg;
    assign res_valid = res_valid_reg;
endmodule

// ----- sv/windowed_alignment_depth_binner.sv -----
// ----------------------------------------------------------------------------
// windowed_alignment_depth_binner
// Sums aligned read bases into fixed-width reference windows and reports
// per-window coverage and fixed-point depth.
// ----------------------------------------------------------------------------
//  channel  | dir | carries
//  ---------+-----+---------------------------------------------------------
//  req      | in  | contig start, read header, cigar op or bin read item
//  res      | out | one bin report item per bin read
//  cfg_*    | in  | register write: window width (0), min_map_quality (1)
//
//  A read header and a cigar op that touches no window are taken at once;
//  a bin read runs a multiply, a memory read and a 40-step divide, the
//  divide left out for a window out of range; a cigar match op runs the
//  divide, then a read-modify-write of the bin memory per window touched;
//  a contig start runs the divide, then, as reset does, a clearing pass
//  over the bin memory, one entry a cycle, during which req is not ready.
//  Output register: req is taken again while a report waits on res; a bin
//  read stalls in its last cycle until the previous report is taken.
// ----------------------------------------------------------------------------
`include "windowed_alignment_depth_binner_macros.svh"

module windowed_alignment_depth_binner #(
    parameter int MAX_BINS = 262144
) (
    input  logic                              clk,
    input  logic                              rst_n,
    wadb_req_if.sink                          req,
    wadb_res_if.source                        res,
    input  logic                              cfg_we,
    input  logic [wadb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wadb_pkg::WS_W-1:0]         cfg_wdata
);
    wadb_pkg::cmd_t cmd;
    wadb_pkg::sts_t sts;
    wadb_pkg::req_t rq;
    wadb_pkg::res_t rs;
    logic           rs_valid;

    // pack the request payload
    assign rq.req_type     = req.req_type;
    assign rq.ref_position = req.ref_position;
    assign rq.span_length  = req.span_length;
    assign rq.read_flags   = req.read_flags;
    assign rq.map_quality  = req.map_quality;
    assign rq.cigar_code   = req.cigar_code;
    assign rq.bin_index    = req.bin_index;

    // sequencer: only idle state takes items
    wadb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath with bin memory and shared divider
    wadb_dp #(
        .MAX_BINS (MAX_BINS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .rq        (rq),
        .cmd       (cmd),
        .sts       (sts),
        .res_ready (res.ready),
        .res       (rs),
        .res_valid (rs_valid)
    );

    assign req.ready = cmd.in_ready;

    assign res.valid            = rs_valid;
    assign res.bin_start        = rs.bin_start;
    assign res.bin_end          = rs.bin_end;
    assign res.covered_bases    = rs.covered_bases;
    assign res.depth_fixed      = rs.depth_fixed;
    assign res.bin_out_of_range = rs.bin_out_of_range;

    // no item is taken while the divider is running
    `WADB_ASSERT_IMP(a_div_blocks_req, sts.div_busy, !req.ready)
    // bin memory is never written while items are taken
    `WADB_ASSERT_IMP(a_wr_blocks_req, cmd.clr_step || cmd.loop_adv, !req.ready)
    // a loaded report is offered on the next cycle
    `WADB_ASSERT_NXT(a_load_shows, cmd.out_load, res.valid)

endmodule
